// ----- hdl/gwps_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package gwps_pkg;

    localparam int COORD_W     = 6;
    localparam int DIM_W       = 7;
    localparam int LEN_W       = 12;
    localparam int LAB_W       = 13;
    localparam int ROUTE_DEPTH = 4096;
    localparam int ROUTE_IW    = 12;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 7;
    localparam int COORD_CAP   = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;

    // neighbour order: +x, +y, -x, -y
    localparam logic [1:0] NB_PX = 2'd0;
    localparam logic [1:0] NB_PY = 2'd1;
    localparam logic [1:0] NB_MX = 2'd2;
    localparam logic [1:0] NB_MY = 2'd3;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_PLACE = 2'd1,
        CMD_MOVE  = 2'd2,
        CMD_STEP  = 2'd3
    } cmd_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_STEP_WB,
        ST_MV_CHK,
        ST_MV_WST,
        ST_MV_WDS,
        ST_CLR,
        ST_SEED,
        ST_QCHK,
        ST_QLAT,
        ST_NB,
        ST_TR_INIT,
        ST_TR_TOP,
        ST_TR_RD,
        ST_TR_EV
    } state_t;

    typedef struct packed {
        logic [1:0]         command;
        logic [COORD_W-1:0] cell_x;
        logic [COORD_W-1:0] cell_y;
        logic               walkable;
        logic [COORD_W-1:0] dest_x;
        logic [COORD_W-1:0] dest_y;
    } in_item_t;

    typedef struct packed {
        logic [LEN_W-1:0]   route_length;
        logic               found;
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
    } out_item_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [LEN_W-1:0]   hops;
    } qent_t;

    typedef struct packed {
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
    } route_ent_t;

    function automatic logic nb_ok(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                                   input logic [1:0] k, input logic [DIM_W-1:0] w,
                                   input logic [DIM_W-1:0] h);
        logic ok;
        case (k)
            NB_PX:   ok = ({1'b0, x} + 7'd1) < w;
            NB_PY:   ok = ({1'b0, y} + 7'd1) < h;
            NB_MX:   ok = (x != '0);
            NB_MY:   ok = (y != '0);
            default: ok = 1'b0;
        endcase
        return ok;
    endfunction

    function automatic logic [COORD_W-1:0] nb_x(input logic [COORD_W-1:0] x,
                                                input logic [1:0] k);
        logic [COORD_W-1:0] r;
        case (k)
            NB_PX:   r = x + 6'd1;
            NB_MX:   r = x - 6'd1;
            default: r = x;
        endcase
        return r;
    endfunction

    function automatic logic [COORD_W-1:0] nb_y(input logic [COORD_W-1:0] y,
                                                input logic [1:0] k);
        logic [COORD_W-1:0] r;
        case (k)
            NB_PY:   r = y + 6'd1;
            NB_MY:   r = y - 6'd1;
            default: r = y;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/gwps_wave_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module gwps_wave_queue
    import gwps_pkg::*;
#(
    parameter int DEPTH = 4096,
    parameter int IW    = 12
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [IW-1:0] wr_idx,
    input  wire qent_t         wr_data,
    input  wire logic [IW-1:0] rd_idx,
    output qent_t              rd_data
);

    qent_t mem [DEPTH];

    // one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
        rd_data <= mem[rd_idx];
    end

endmodule

`default_nettype wire

// ----- hdl/gwps_route_store.sv -----
`timescale 1ns / 1ps
`default_nettype none

module gwps_route_store
    import gwps_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                wr_en,
    input  wire logic [ROUTE_IW-1:0] wr_idx,
    input  wire route_ent_t          wr_data,
    input  wire logic [ROUTE_IW-1:0] rd_idx,
    output route_ent_t               rd_data
);

    route_ent_t mem [ROUTE_DEPTH];

    // route entries, index 0 nearest the destination
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
        rd_data <= mem[rd_idx];
    end

endmodule

`default_nettype wire

// ----- hdl/grid_wave_path_search.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Lee wave path search over a grid of up to 64 x 64 cells. Commands are taken
// when start is high and busy is low; each command gives one result beat on
// result_valid, one cycle wide, which the receiver must take as it comes.
// Load and place are done at once and a step reads the route store first, the
// next command being taken while the result is shown. A move checks the start
// and destination, clears the label memory over the grid in use, takes cells
// off the wave queue one at a time and then traces the route back, each phase
// paced by the single read port of the label and wall memories.
// Cells never loaded must not be reached by a move.
module grid_wave_path_search
    import gwps_pkg::*;
#(
    parameter int MAX_DIM = 64
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire in_item_t              in_item,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output logic                       result_valid,
    output out_item_t                  result
);

    localparam int CELLS     = MAX_DIM * MAX_DIM;
    localparam int AW        = $clog2(CELLS);
    localparam int COORD_LIM = (MAX_DIM < COORD_CAP) ? MAX_DIM : COORD_CAP;
    localparam int QD        = (CELLS < ROUTE_DEPTH) ? CELLS : ROUTE_DEPTH;
    localparam int QW        = $clog2(QD);

    function automatic logic [AW-1:0] addr_of(input logic [COORD_W-1:0] x,
                                             input logic [COORD_W-1:0] y);
        return AW'(AW'(y) * AW'(MAX_DIM) + AW'(x));
    endfunction

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = 7'd1;
        else if (int'(v) > COORD_LIM)
            r = DIM_W'(COORD_LIM);
        else
            r = v;
        return r;
    endfunction

    state_t             state_reg, state_next;
    logic [COORD_W-1:0] pos_x_reg, pos_x_next, pos_y_reg, pos_y_next;
    logic [LEN_W-1:0]   count_reg, count_next;
    logic               found_reg, found_next;
    logic               done_reg, done_next;
    logic [DIM_W-1:0]   w_reg, h_reg;
    logic [COORD_W-1:0] dst_x_reg, dst_x_next, dst_y_reg, dst_y_next;
    logic [COORD_W-1:0] cur_x_reg, cur_x_next, cur_y_reg, cur_y_next;
    logic [LEN_W-1:0]   cur_d_reg, cur_d_next;
    logic [2:0]         k_reg, k_next;
    logic [QW:0]        head_reg, head_next, tail_reg, tail_next;
    logic               reached_reg, reached_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic               pend_reg, pend_next;
    logic [COORD_W-1:0] pend_x_reg, pend_x_next, pend_y_reg, pend_y_next;
    logic [LEN_W-1:0]   ridx_reg, ridx_next, d_reg, d_next;

    logic [COORD_W-1:0] rd_x, rd_y, dw_x, dw_y;
    logic               dist_we, walk_we;
    logic [LAB_W-1:0]   dist_wdata;
    logic               walk_rd_reg;
    logic [LAB_W-1:0]   dist_rd_reg;
    logic               q_we, r_we;
    qent_t              q_wdata, q_rdata;
    logic [QW-1:0]      q_ridx;
    route_ent_t         r_wdata, r_rdata;
    logic [ROUTE_IW-1:0] r_ridx;
    logic               nb_valid;
    logic [COORD_W-1:0] nbx, nby;

    logic               walk_mem [CELLS];
    logic [LAB_W-1:0]   dist_mem [CELLS];

    // wall and label memories, label 0 means not reached
    always_ff @(posedge clk)
    begin
        if (walk_we)
        begin
            walk_mem[addr_of(in_item.cell_x, in_item.cell_y)] <= in_item.walkable;
        end
        walk_rd_reg <= walk_mem[addr_of(rd_x, rd_y)];
    end

    always_ff @(posedge clk)
    begin
        if (dist_we)
        begin
            dist_mem[addr_of(dw_x, dw_y)] <= dist_wdata;
        end
        dist_rd_reg <= dist_mem[addr_of(rd_x, rd_y)];
    end

    gwps_wave_queue #(
        .DEPTH (QD),
        .IW    (QW)
    ) u_queue (
        .clk     (clk),
        .wr_en   (q_we),
        .wr_idx  (tail_reg[QW-1:0]),
        .wr_data (q_wdata),
        .rd_idx  (q_ridx),
        .rd_data (q_rdata)
    );

    gwps_route_store u_route (
        .clk     (clk),
        .wr_en   (r_we),
        .wr_idx  (ridx_reg),
        .wr_data (r_wdata),
        .rd_idx  (r_ridx),
        .rd_data (r_rdata)
    );

    // neighbour of the current cell under k
    always_comb
    begin
        nb_valid = ~k_reg[2] & nb_ok(cur_x_reg, cur_y_reg, k_reg[1:0], w_reg, h_reg);
        nbx      = nb_x(cur_x_reg, k_reg[1:0]);
        nby      = nb_y(cur_y_reg, k_reg[1:0]);
    end

    // command sequencer
    always_comb
    begin
        state_next   = state_reg;
        pos_x_next   = pos_x_reg;
        pos_y_next   = pos_y_reg;
        count_next   = count_reg;
        found_next   = found_reg;
        done_next    = 1'b0;
        dst_x_next   = dst_x_reg;
        dst_y_next   = dst_y_reg;
        cur_x_next   = cur_x_reg;
        cur_y_next   = cur_y_reg;
        cur_d_next   = cur_d_reg;
        k_next       = k_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        reached_next = reached_reg;
        len_next     = len_reg;
        pend_next    = pend_reg;
        pend_x_next  = pend_x_reg;
        pend_y_next  = pend_y_reg;
        ridx_next    = ridx_reg;
        d_next       = d_reg;
        rd_x         = cur_x_reg;
        rd_y         = cur_y_reg;
        dw_x         = cur_x_reg;
        dw_y         = cur_y_reg;
        dist_we      = 1'b0;
        dist_wdata   = '0;
        walk_we      = 1'b0;
        q_we         = 1'b0;
        q_wdata      = '{x: pos_x_reg, y: pos_y_reg, hops: '0};
        q_ridx       = head_reg[QW-1:0];
        r_we         = 1'b0;
        r_wdata      = '{y: cur_y_reg, x: cur_x_reg};
        r_ridx       = count_reg - 12'd1;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (cmd_t'(in_item.command))
                        CMD_LOAD:
                        begin
                            walk_we   = (int'(in_item.cell_x) < MAX_DIM) &&
                                        (int'(in_item.cell_y) < MAX_DIM);
                            done_next = 1'b1;
                        end
                        CMD_PLACE:
                        begin
                            pos_x_next = in_item.cell_x;
                            pos_y_next = in_item.cell_y;
                            count_next = '0;
                            found_next = 1'b0;
                            done_next  = 1'b1;
                        end
                        CMD_MOVE:
                        begin
                            dst_x_next = in_item.dest_x;
                            dst_y_next = in_item.dest_y;
                            state_next = ST_MV_CHK;
                        end
                        CMD_STEP:
                        begin
                            if (count_reg != '0)
                                state_next = ST_STEP_WB;
                            else
                                done_next = 1'b1;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            ST_STEP_WB:
            begin
                pos_x_next = r_rdata.x;
                pos_y_next = r_rdata.y;
                count_next = count_reg - 12'd1;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end

            // start and destination inside the grid
            ST_MV_CHK:
            begin
                if (({1'b0, pos_x_reg} >= w_reg) || ({1'b0, pos_y_reg} >= h_reg) ||
                    ({1'b0, dst_x_reg} >= w_reg) || ({1'b0, dst_y_reg} >= h_reg))
                begin
                    count_next = '0;
                    found_next = 1'b0;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    rd_x       = pos_x_reg;
                    rd_y       = pos_y_reg;
                    state_next = ST_MV_WST;
                end
            end

            ST_MV_WST:
            begin
                rd_x = dst_x_reg;
                rd_y = dst_y_reg;
                if (!walk_rd_reg)
                begin
                    count_next = '0;
                    found_next = 1'b0;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_MV_WDS;
                end
            end

            ST_MV_WDS:
            begin
                if (!walk_rd_reg)
                begin
                    count_next = '0;
                    found_next = 1'b0;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cur_x_next = '0;
                    cur_y_next = '0;
                    tail_next  = '0;
                    state_next = ST_CLR;
                end
            end

            // clear labels over the grid in use
            ST_CLR:
            begin
                dist_we = 1'b1;
                if (({1'b0, cur_x_reg} + 7'd1) == w_reg)
                begin
                    cur_x_next = '0;
                    cur_y_next = cur_y_reg + 6'd1;
                    if (({1'b0, cur_y_reg} + 7'd1) == h_reg)
                        state_next = ST_SEED;
                end
                else
                begin
                    cur_x_next = cur_x_reg + 6'd1;
                end
            end

            ST_SEED:
            begin
                dw_x         = pos_x_reg;
                dw_y         = pos_y_reg;
                dist_we      = 1'b1;
                dist_wdata   = 13'd1;
                q_we         = 1'b1;
                head_next    = '0;
                tail_next    = (QW+1)'(1);
                reached_next = (pos_x_reg == dst_x_reg) && (pos_y_reg == dst_y_reg);
                len_next     = '0;
                state_next   = ST_QCHK;
            end

            ST_QCHK:
            begin
                if (reached_reg)
                begin
                    state_next = ST_TR_INIT;
                end
                else if (head_reg < tail_reg)
                begin
                    head_next  = head_reg + 1'b1;
                    state_next = ST_QLAT;
                end
                else
                begin
                    count_next = '0;
                    found_next = 1'b0;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            ST_QLAT:
            begin
                cur_x_next = q_rdata.x;
                cur_y_next = q_rdata.y;
                cur_d_next = q_rdata.hops;
                k_next     = '0;
                pend_next  = 1'b0;
                state_next = ST_NB;
            end

            // label the neighbour read last cycle, read the next one
            ST_NB:
            begin
                if (pend_reg && walk_rd_reg && (dist_rd_reg == '0))
                begin
                    dw_x       = pend_x_reg;
                    dw_y       = pend_y_reg;
                    dist_we    = 1'b1;
                    dist_wdata = LAB_W'(cur_d_reg) + 13'd2;
                    q_we       = 1'b1;
                    q_wdata    = '{x: pend_x_reg, y: pend_y_reg, hops: cur_d_reg + 12'd1};
                    tail_next  = tail_reg + 1'b1;
                    if ((pend_x_reg == dst_x_reg) && (pend_y_reg == dst_y_reg))
                    begin
                        reached_next = 1'b1;
                        len_next     = cur_d_reg + 12'd1;
                    end
                end
                rd_x        = nbx;
                rd_y        = nby;
                pend_x_next = nbx;
                pend_y_next = nby;
                pend_next   = nb_valid;
                if (k_reg[2])
                    state_next = ST_QCHK;
                else
                    k_next = k_reg + 3'd1;
            end

            ST_TR_INIT:
            begin
                cur_x_next = dst_x_reg;
                cur_y_next = dst_y_reg;
                d_next     = len_reg;
                ridx_next  = '0;
                state_next = ST_TR_TOP;
            end

            ST_TR_TOP:
            begin
                if (d_reg == '0)
                begin
                    count_next = len_reg;
                    found_next = 1'b1;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    r_we       = 1'b1;
                    ridx_next  = ridx_reg + 12'd1;
                    d_next     = d_reg - 12'd1;
                    k_next     = '0;
                    state_next = ST_TR_RD;
                end
            end

            ST_TR_RD:
            begin
                rd_x        = nbx;
                rd_y        = nby;
                pend_x_next = nbx;
                pend_y_next = nby;
                if (k_reg[2])
                    state_next = ST_TR_TOP;
                else if (nb_valid)
                    state_next = ST_TR_EV;
                else
                    k_next = k_reg + 3'd1;
            end

            // first neighbour one step nearer the start
            ST_TR_EV:
            begin
                if (dist_rd_reg == (LAB_W'(d_reg) + 13'd1))
                begin
                    cur_x_next = pend_x_reg;
                    cur_y_next = pend_y_reg;
                    state_next = ST_TR_TOP;
                end
                else
                begin
                    k_next     = k_reg + 3'd1;
                    state_next = ST_TR_RD;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            pos_x_reg   <= '0;
            pos_y_reg   <= '0;
            count_reg   <= '0;
            found_reg   <= 1'b0;
            done_reg    <= 1'b0;
            reached_reg <= 1'b0;
            pend_reg    <= 1'b0;
            head_reg    <= '0;
            tail_reg    <= '0;
            k_reg       <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            pos_x_reg   <= pos_x_next;
            pos_y_reg   <= pos_y_next;
            count_reg   <= count_next;
            found_reg   <= found_next;
            done_reg    <= done_next;
            reached_reg <= reached_next;
            pend_reg    <= pend_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            k_reg       <= k_next;
        end
    end

    // working registers of a move
    always_ff @(posedge clk)
    begin
        dst_x_reg  <= dst_x_next;
        dst_y_reg  <= dst_y_next;
        cur_x_reg  <= cur_x_next;
        cur_y_reg  <= cur_y_next;
        cur_d_reg  <= cur_d_next;
        len_reg    <= len_next;
        pend_x_reg <= pend_x_next;
        pend_y_reg <= pend_y_next;
        ridx_reg   <= ridx_next;
        d_reg      <= d_next;
    end

    // grid size registers, held clamped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg <= DIM_W'(COORD_LIM);
            h_reg <= DIM_W'(COORD_LIM);
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_GRID_WIDTH)
                w_reg <= clamp_dim(cfg_data);
            else if (cfg_index == CFG_GRID_HEIGHT)
                h_reg <= clamp_dim(cfg_data);
        end
    end

    // result beat
    assign cfg_ready    = 1'b1;
    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = done_reg;
    assign result       = '{route_length: count_reg, found: found_reg,
                            pos_x: pos_x_reg, pos_y: pos_y_reg};

endmodule

`default_nettype wire
